### sv/pan_tilt_scan_to_point_unit_defines.svh
// Assertion helpers for the pan-tilt point unit.
`ifndef PAN_TILT_SCAN_TO_POINT_UNIT_DEFINES_SVH
`define PAN_TILT_SCAN_TO_POINT_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define PTS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define PTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/pts_pkg.sv
package pts_pkg;
  localparam int unsigned MaxBeamsDef = 1024;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned AngW = 21;   // reduced angle, Q.16
  localparam int unsigned CsW  = 19;   // cordic x/y
  localparam logic signed [AngW-1:0] Pi16   = 21'sd205887;
  localparam logic signed [AngW-1:0] Half16 = 21'sd102944;
  localparam logic signed [CsW-1:0]  Gain0  = 19'sd39796;
  localparam int unsigned OutW = 21;

  // Angle reduction: bias by two full turns so every angle is positive,
  // then estimate the turn count with a reciprocal of 2*pi scaled by 2^27.
  localparam logic [27:0] WrapBias = 28'd823548;
  localparam logic [8:0]  RecipK   = 9'd325;
  localparam logic [19:0] TwoPi16  = 20'd411774;

  typedef enum logic [2:0] {
    RegAngleInc  = 3'd0,
    RegStartAng  = 3'd1,
    RegTiltArm   = 3'd2,
    RegPanArm    = 3'd3,
    RegBaseHgt   = 3'd4,
    RegBaseShift = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [CsW-1:0]  x;
    logic signed [CsW-1:0]  y;
    logic signed [AngW-1:0] z;
    logic                   flip;
  } cordic_t;

  function automatic logic signed [AngW-1:0] atan_c(input int unsigned i);
    logic signed [AngW-1:0] t;
    case (i)
      0: t = 21'sd51472;
      1: t = 21'sd30385;
      2: t = 21'sd16055;
      3: t = 21'sd8150;
      4: t = 21'sd4091;
      5: t = 21'sd2047;
      6: t = 21'sd1024;
      7: t = 21'sd512;
      8: t = 21'sd256;
      9: t = 21'sd128;
      10: t = 21'sd64;
      11: t = 21'sd32;
      12: t = 21'sd16;
      13: t = 21'sd8;
      14: t = 21'sd4;
      default: t = 21'sd2;
    endcase
    return t;
  endfunction
endpackage

### sv/pts_cordic_cell.sv
module pts_cordic_cell #(
  parameter int unsigned Step = 0
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  pts_pkg::cordic_t a_i,
  input  pts_pkg::cordic_t b_i,
  input  pts_pkg::cordic_t c_i,
  output pts_pkg::cordic_t a_o,
  output pts_pkg::cordic_t b_o,
  output pts_pkg::cordic_t c_o
);
  import pts_pkg::*;

  function automatic cordic_t rot(input cordic_t v);
    cordic_t r;
    r = v;
    if (!v.z[AngW-1]) begin
      r.x = v.x - ($signed(v.y) >>> Step);
      r.y = v.y + ($signed(v.x) >>> Step);
      r.z = v.z - atan_c(Step);
    end else begin
      r.x = v.x + ($signed(v.y) >>> Step);
      r.y = v.y - ($signed(v.x) >>> Step);
      r.z = v.z + atan_c(Step);
    end
    return r;
  endfunction

  cordic_t a_q, b_q, c_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= rot(a_i);
      b_q <= rot(b_i);
      c_q <= rot(c_i);
    end
  end

  assign a_o = a_q;
  assign b_o = b_q;
  assign c_o = c_q;
endmodule

### sv/pts_prep.sv
module pts_prep (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [27:0]    th_i,
  output pts_pkg::cordic_t      seed_o
);
  import pts_pkg::*;

  logic signed [27:0] thb;
  logic [26:0] thp;
  logic [35:0] qprod;
  logic [26:0] th1_q;
  logic [7:0]  q1_q;
  logic [26:0] rem;
  logic [19:0] rem2_q;
  logic [19:0] u;
  logic signed [AngW-1:0] t;
  cordic_t seed_d, seed_q;

  // Estimated turn count is low by at most one, so the remainder is below 4*pi.
  assign thb   = th_i + $signed(WrapBias);
  assign thp   = thb[26:0];
  assign qprod = 36'(thp) * 36'(RecipK);
  assign rem   = th1_q - 27'(q1_q) * 27'(TwoPi16);

  // Bring into (-pi, pi], then fold into the cordic range.
  always_comb begin
    u = (rem2_q >= TwoPi16) ? rem2_q - TwoPi16 : rem2_q;
    t = $signed({1'b0, u});
    if (t > Pi16) t = t - $signed({1'b0, TwoPi16});
    seed_d.flip = 1'b0;
    if (t > Half16) begin
      t = t - Pi16;
      seed_d.flip = 1'b1;
    end else if (t < -Half16) begin
      t = t + Pi16;
      seed_d.flip = 1'b1;
    end
    seed_d.x = Gain0;
    seed_d.y = '0;
    seed_d.z = t;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      th1_q  <= thp;
      q1_q   <= qprod[34:27];
      rem2_q <= rem[19:0];
      seed_q <= seed_d;
    end
  end

  assign seed_o = seed_q;
endmodule

### sv/pan_tilt_scan_to_point_unit.sv
// Pan-tilt laser point transform.
// Input channel: range_value_i, beam_index_i, pan_angle_i, tilt_angle_i with
// in_valid_i / in_ready_o. Output channel: point_x_o, point_y_o, point_z_o
// (signed Q8.12) with out_valid_o / out_ready_i.
// Configuration: cfg_we_i, cfg_idx_i, cfg_data_i; write only while idle.
// Throughput: one word per cycle unless the output stalls. An accepted word
// reaches the outputs through beam angle, three stages of mod 2*pi reduction and
// fold, a chain of 16 cordic cells that rotate beam, pan and tilt side by
// side, then sign fix, two multiply stages, a sum stage, a multiply stage,
// the final sum and the rounded, saturated output register.
// The pipeline advances as a whole; a stall at the output freezes every
// stage, and the last stage's register acts as the output register, so
// in_ready_o follows out_ready_i or an empty output slot.
// Reset clears the valid bits and loads the register defaults
// (start angle -2.094, offsets 0.045, 0.040, 0.114, 0.02845).
`include "pan_tilt_scan_to_point_unit_defines.svh"
module pan_tilt_scan_to_point_unit #(
  parameter int unsigned MaxBeams = pts_pkg::MaxBeamsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [15:0]          range_value_i,
  input  logic [9:0]           beam_index_i,
  input  logic signed [15:0]   pan_angle_i,
  input  logic signed [15:0]   tilt_angle_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [20:0]   point_x_o,
  output logic signed [20:0]   point_y_o,
  output logic signed [20:0]   point_z_o
);
  import pts_pkg::*;

  localparam int unsigned PrepSteps = 3;
  localparam int unsigned RngTaps   = 1 + PrepSteps + CordicSteps + 1;
  localparam int unsigned Depth     = RngTaps + 6;

  logic [15:0] inc_q;
  logic signed [15:0] start_q, l1_q, l2_q, d1_q, d2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q   <= '0;
      start_q <= -16'sd8577;
      l1_q    <= 16'sd184;
      l2_q    <= 16'sd164;
      d1_q    <= 16'sd467;
      d2_q    <= 16'sd117;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegAngleInc:  inc_q   <= cfg_data_i;
        RegStartAng:  start_q <= cfg_data_i;
        RegTiltArm:   l1_q    <= cfg_data_i;
        RegPanArm:    l2_q    <= cfg_data_i;
        RegBaseHgt:   d1_q    <= cfg_data_i;
        RegBaseShift: d2_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [Depth-1:0] vld_q;
  logic adv;
  assign adv         = out_ready_i || !vld_q[Depth-1];
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[Depth-2:0], in_valid_i};
  end

  // Stage 0: beam angle.
  logic [9:0] idx_sat;
  logic [25:0] idx_inc;
  logic signed [15:0] pan0_q, tilt0_q;
  logic signed [27:0] beam0_q;
  logic [RngTaps-1:0][15:0] rng_q;

  always_comb begin
    if (32'(beam_index_i) >= MaxBeams) idx_sat = 10'(MaxBeams - 1);
    else idx_sat = beam_index_i;
  end
  assign idx_inc = 26'(idx_sat) * 26'(inc_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pan0_q  <= pan_angle_i;
      tilt0_q <= tilt_angle_i;
      beam0_q <= 28'($signed({start_q, 4'b0})) + $signed({2'b00, idx_inc});
      rng_q   <= {rng_q[RngTaps-2:0], range_value_i};
    end
  end

  // Angle reduction and fold, then the cordic chain.
  cordic_t ch_b [CordicSteps+1];
  cordic_t ch_p [CordicSteps+1];
  cordic_t ch_t [CordicSteps+1];

  pts_prep u_prep_beam (
    .clk_i (clk_i), .en_i (adv), .th_i (beam0_q), .seed_o (ch_b[0])
  );
  pts_prep u_prep_pan (
    .clk_i (clk_i), .en_i (adv), .th_i (28'($signed({pan0_q, 4'b0}))),
    .seed_o (ch_p[0])
  );
  pts_prep u_prep_tilt (
    .clk_i (clk_i), .en_i (adv), .th_i (28'($signed({tilt0_q, 4'b0}))),
    .seed_o (ch_t[0])
  );

  for (genvar g = 0; g < CordicSteps; g++) begin : g_chain
    pts_cordic_cell #(.Step(g)) u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (ch_b[g]),
      .b_i   (ch_p[g]),
      .c_i   (ch_t[g]),
      .a_o   (ch_b[g+1]),
      .b_o   (ch_p[g+1]),
      .c_o   (ch_t[g+1])
    );
  end

  // Sign fix: undo the fold.
  cordic_t fb, fp, ft;
  logic signed [CsW-1:0] cb_q, sb_q, cp0_q, sp0_q, ct0_q, st0_q;
  assign fb = ch_b[CordicSteps];
  assign fp = ch_p[CordicSteps];
  assign ft = ch_t[CordicSteps];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cb_q  <= fb.flip ? -fb.x : fb.x;
      sb_q  <= fb.flip ? -fb.y : fb.y;
      cp0_q <= fp.flip ? -fp.x : fp.x;
      sp0_q <= fp.flip ? -fp.y : fp.y;
      ct0_q <= ft.flip ? -ft.x : ft.x;
      st0_q <= ft.flip ? -ft.y : ft.y;
    end
  end

  // Planar point and tilt arm term, rounded to Q.16.
  logic signed [19:0] l1x, l2x;
  logic signed [39:0] xx_p, yy_p;
  logic signed [47:0] l1s_p;
  logic signed [23:0] xx1_q, yy1_q, l1s1_q;
  logic signed [CsW-1:0] cp1_q, sp1_q, ct1_q, st1_q;

  assign l1x   = $signed({l1_q, 4'b0});
  assign l2x   = $signed({l2_q, 4'b0});
  assign xx_p  = 40'($signed({1'b0, rng_q[RngTaps-1]})) * 40'(cb_q) + 40'sd512;
  assign yy_p  = 40'($signed({1'b0, rng_q[RngTaps-1]})) * 40'(sb_q) + 40'sd512;
  assign l1s_p = 48'(l1x) * 48'(st0_q) + 48'sd32768;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xx1_q  <= xx_p[33:10];
      yy1_q  <= yy_p[33:10];
      l1s1_q <= l1s_p[39:16];
      cp1_q  <= cp0_q;
      sp1_q  <= sp0_q;
      ct1_q  <= ct0_q;
      st1_q  <= st0_q;
    end
  end

  // Tilt applied to the in-plane y term.
  logic signed [47:0] a_p;
  logic signed [23:0] a2_q, xx2_q, yy2_q, l1s2_q;
  logic signed [CsW-1:0] cp2_q, sp2_q, ct2_q, st2_q;
  assign a_p = 48'(yy1_q) * 48'(ct1_q) + 48'sd32768;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a2_q   <= a_p[39:16];
      xx2_q  <= xx1_q;
      yy2_q  <= yy1_q;
      l1s2_q <= l1s1_q;
      cp2_q  <= cp1_q;
      sp2_q  <= sp1_q;
      ct2_q  <= ct1_q;
      st2_q  <= st1_q;
    end
  end

  // Gather the factors of sin(pan) for x and cos(pan) for y.
  logic signed [25:0] s1_q, s2_q;
  logic signed [23:0] xx3_q, yy3_q;
  logic signed [CsW-1:0] cp3_q, sp3_q, ct3_q, st3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q  <= 26'(l1s2_q) + 26'(l2x) - 26'(a2_q);
      s2_q  <= 26'(a2_q) - 26'(l1s2_q) + 26'(l2x);
      xx3_q <= xx2_q;
      yy3_q <= yy2_q;
      cp3_q <= cp2_q;
      sp3_q <= sp2_q;
      ct3_q <= ct2_q;
      st3_q <= st2_q;
    end
  end

  // Products in Q.32.
  logic signed [47:0] px1_q, px2_q, py1_q, py2_q, pz1_q, pz2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px1_q <= 48'(xx3_q) * 48'(cp3_q);
      px2_q <= 48'(s1_q) * 48'(sp3_q);
      py1_q <= 48'(xx3_q) * 48'(sp3_q);
      py2_q <= 48'(s2_q) * 48'(cp3_q);
      pz1_q <= 48'(yy3_q) * 48'(st3_q);
      pz2_q <= 48'(l1x) * 48'(ct3_q);
    end
  end

  logic signed [47:0] sx_q, sy_q, sz_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx_q <= px1_q + px2_q;
      sy_q <= py1_q + py2_q - 48'($signed({d2_q, 20'b0}));
      sz_q <= pz1_q + pz2_q + 48'($signed({d1_q, 20'b0}));
    end
  end

  // Round Q.32 to Q8.12 and clamp.
  function automatic logic signed [OutW-1:0] to_out(input logic signed [47:0] v);
    logic signed [47:0] r;
    logic signed [27:0] w;
    logic signed [OutW-1:0] res;
    r = v + 48'sd524288;
    w = r[47:20];
    if (w > 28'sd1048575) res = 21'sd1048575;
    else if (w < -28'sd1048576) res = -21'sd1048576;
    else res = w[OutW-1:0];
    return res;
  endfunction

  logic signed [OutW-1:0] px_q, py_q, pz_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q <= to_out(sx_q);
      py_q <= to_out(sy_q);
      pz_q <= to_out(sz_q);
    end
  end

  assign point_x_o = px_q;
  assign point_y_o = py_q;
  assign point_z_o = pz_q;

  `PTS_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "output word dropped")
  `PTS_ASSERT_NXT(a_out_stable, out_valid_o && !out_ready_i, $stable({point_x_o, point_y_o, point_z_o}), "output word changed while held")
  `PTS_ASSERT(a_ready_rule, 1'b1, in_ready_o == (out_ready_i || !out_valid_o), "in_ready_o out of step with output slot")
endmodule
